// ===== src/gpla_pkg.sv =====
package gpla_pkg;

    // Command codes
    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_DISCARD = 2'd2;
    localparam logic [1:0] OP_LOCAL   = 2'd3;

    // Lock status codes
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_LOW  = 2'd1;
    localparam logic [1:0] ST_HIGH = 2'd2;
    localparam logic [1:0] ST_ACQ  = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  requester;
        logic [15:0] group;
    } cmd_t;

    typedef struct packed {
        logic [7:0] target;
        logic [1:0] lock_status;
        logic       error;
        logic       last;
    } result_t;

    // One waiting entry of the queue memory
    typedef struct packed {
        logic [15:0] group;
        logic [7:0]  rank;
        logic        high;
    } entry_t;

    typedef struct packed {
        logic [7:0] target;
        logic [1:0] lock_status;
        logic       error;
    } res_t;

    // Sequencer to output stage: push one result, or close the item
    typedef struct packed {
        logic vld;
        logic flush;
        res_t res;
    } emit_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_DSC,
        S_GRT,
        S_DEM,
        S_NOTE,
        S_FLUSH
    } state_t;

endpackage

// ===== src/gpla_ram.sv =====
module gpla_ram
    #(
        parameter int WIDTH = 25,
        parameter int DEPTH = 16
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic                     re,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/gpla_emit.sv =====
module gpla_emit
    import gpla_pkg::*;
    (
        input  logic      clk,
        input  logic      rst_n,
        input  emit_req_t req,
        output logic      strobe,
        output result_t   result
    );

    logic    pend_vld_reg, pend_vld_next;
    res_t    pend_reg, pend_next;
    logic    strobe_reg, strobe_next;
    result_t result_reg, result_next;

    // Hold each result one step so the final one of an item can carry last
    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;
        if (req.vld)
        begin
            pend_next     = req.res;
            pend_vld_next = 1'b1;
            if (pend_vld_reg)
            begin
                strobe_next = 1'b1;
                result_next = '{target: pend_reg.target, lock_status: pend_reg.lock_status,
                                error: pend_reg.error, last: 1'b0};
            end
        end
        else if (req.flush)
        begin
            pend_vld_next = 1'b0;
            if (pend_vld_reg)
            begin
                strobe_next = 1'b1;
                result_next = '{target: pend_reg.target, lock_status: pend_reg.lock_status,
                                error: pend_reg.error, last: 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    a_push_xor_flush: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.vld && req.flush))
        else $error("push and flush in the same cycle");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.last) |-> !pend_vld_reg)
        else $error("result left pending after last");

    a_error_status: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.error) |-> (result_reg.lock_status == ST_NONE))
        else $error("error result with nonzero status");

endmodule

// ===== src/gpla_seq.sv =====
module gpla_seq
    import gpla_pkg::*;
    #(
        parameter int DEPTH = 16
    )
    (
        input  logic                     clk,
        input  logic                     rst_n,
        input  logic                     start,
        input  cmd_t                     cmd,
        output logic                     busy,
        output emit_req_t                emit,
        output logic                     ram_we,
        output logic [$clog2(DEPTH)-1:0] ram_waddr,
        output entry_t                   ram_wdata,
        output logic                     ram_re,
        output logic [$clog2(DEPTH)-1:0] ram_raddr,
        input  entry_t                   ram_rdata
    );

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          hv_reg, hv_next;
    logic [15:0]   hgroup_reg, hgroup_next;
    logic [7:0]    hrank_reg, hrank_next;
    cmd_t          req_reg, req_next;
    logic          high_reg, high_next;
    logic          notify_reg, notify_next;
    logic          found_reg, found_next;
    logic          demote_reg, demote_next;

    logic          high_now;
    logic          do_release;
    logic          do_notify;
    logic          hit;
    entry_t        new_entry;
    res_t          put_res;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        hv_next     = hv_reg;
        hgroup_next = hgroup_reg;
        hrank_next  = hrank_reg;
        req_next    = req_reg;
        high_next   = high_reg;
        notify_next = notify_reg;
        found_next  = found_reg;
        demote_next = demote_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = idx_reg;
        emit        = '0;
        do_release  = 1'b0;
        do_notify   = 1'b0;

        high_now  = cmd.group < hgroup_reg;
        new_entry = '{group: req_reg.group, rank: req_reg.requester, high: high_reg};
        put_res   = '{target: req_reg.requester,
                      lock_status: (high_reg ? ST_HIGH : ST_LOW), error: 1'b0};
        hit       = !found_reg && (ram_rdata.group == req_reg.group)
                    && (ram_rdata.rank == req_reg.requester);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next  = cmd;
                    high_next = high_now;
                    case (cmd.op)
                        OP_ACQUIRE:
                        begin
                            state_next = S_FLUSH;
                            if (!hv_reg)
                            begin
                                hv_next     = 1'b1;
                                hgroup_next = cmd.group;
                                hrank_next  = cmd.requester;
                                emit.vld    = 1'b1;
                                emit.res    = '{target: cmd.requester, lock_status: ST_ACQ,
                                                error: 1'b0};
                            end
                            else if (count_reg == CW'(DEPTH))
                            begin
                                emit.vld = 1'b1;
                                emit.res = '{target: cmd.requester, lock_status: ST_NONE,
                                             error: 1'b1};
                            end
                            else if (count_reg == '0)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                ram_wdata  = '{group: cmd.group, rank: cmd.requester,
                                               high: high_now};
                                count_next = count_reg + CW'(1);
                                emit.vld   = 1'b1;
                                emit.res   = '{target: cmd.requester,
                                               lock_status: (high_now ? ST_HIGH : ST_LOW),
                                               error: 1'b0};
                            end
                            else
                            begin
                                // walk down from the tail, shifting larger groups up
                                ram_re     = 1'b1;
                                ram_raddr  = IW'(count_reg - CW'(1));
                                idx_next   = IW'(count_reg - CW'(1));
                                state_next = S_INS;
                            end
                        end
                        OP_RELEASE, OP_DISCARD:
                        begin
                            if (hv_reg && (hrank_reg == cmd.requester))
                            begin
                                do_release = 1'b1;
                                do_notify  = 1'b1;
                            end
                            else if ((cmd.op == OP_DISCARD) && (count_reg != '0))
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                idx_next   = '0;
                                found_next = 1'b0;
                                state_next = S_DSC;
                            end
                            else
                            begin
                                emit.vld   = 1'b1;
                                emit.res   = '{target: cmd.requester, lock_status: ST_NONE,
                                               error: 1'b1};
                                state_next = S_FLUSH;
                            end
                        end
                        OP_LOCAL:
                        begin
                            do_release = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase

                    if (do_release)
                    begin
                        hv_next     = 1'b0;
                        notify_next = do_notify;
                        if (count_reg == '0)
                        begin
                            state_next = do_notify ? S_NOTE : S_FLUSH;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            state_next = S_GRT;
                        end
                    end
                end
            end

            S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg + IW'(1);
                if (ram_rdata.group > req_reg.group)
                begin
                    ram_wdata = ram_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        idx_next  = idx_reg - IW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg - IW'(1);
                    end
                end
                else
                begin
                    ram_wdata  = new_entry;
                    count_next = count_reg + CW'(1);
                    emit.vld   = 1'b1;
                    emit.res   = put_res;
                    state_next = S_FLUSH;
                end
            end

            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = new_entry;
                count_next = count_reg + CW'(1);
                emit.vld   = 1'b1;
                emit.res   = put_res;
                state_next = S_FLUSH;
            end

            S_DSC:
            begin
                // after the match, move each later entry down one place
                if (found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg - IW'(1);
                    ram_wdata = ram_rdata;
                end
                if (hit)
                begin
                    found_next = 1'b1;
                end
                if (CW'(idx_reg) == count_reg - CW'(1))
                begin
                    emit.vld   = 1'b1;
                    state_next = S_FLUSH;
                    if (found_reg || hit)
                    begin
                        count_next = count_reg - CW'(1);
                        emit.res   = '{target: req_reg.requester, lock_status: ST_NONE,
                                       error: 1'b0};
                    end
                    else
                    begin
                        emit.res = '{target: req_reg.requester, lock_status: ST_NONE,
                                     error: 1'b1};
                    end
                end
                else
                begin
                    idx_next  = idx_reg + IW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + IW'(1);
                end
            end

            S_GRT:
            begin
                hv_next     = 1'b1;
                hgroup_next = ram_rdata.group;
                hrank_next  = ram_rdata.rank;
                count_next  = count_reg - CW'(1);
                emit.vld    = 1'b1;
                emit.res    = '{target: ram_rdata.rank, lock_status: ST_ACQ, error: 1'b0};
                if (count_reg == CW'(1))
                begin
                    state_next = notify_reg ? S_NOTE : S_FLUSH;
                end
                else
                begin
                    idx_next    = IW'(1);
                    ram_re      = 1'b1;
                    ram_raddr   = IW'(1);
                    demote_next = 1'b1;
                    state_next  = S_DEM;
                end
            end

            S_DEM:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg - IW'(1);
                ram_wdata = ram_rdata;
                if (demote_reg && ram_rdata.high)
                begin
                    ram_wdata.high = 1'b0;
                    emit.vld       = 1'b1;
                    emit.res       = '{target: ram_rdata.rank, lock_status: ST_LOW,
                                       error: 1'b0};
                end
                else
                begin
                    demote_next = 1'b0;
                end
                // count already dropped by one: it now names the last old index
                if (CW'(idx_reg) == count_reg)
                begin
                    state_next = notify_reg ? S_NOTE : S_FLUSH;
                end
                else
                begin
                    idx_next  = idx_reg + IW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + IW'(1);
                end
            end

            S_NOTE:
            begin
                emit.vld   = 1'b1;
                emit.res   = '{target: req_reg.requester, lock_status: ST_NONE, error: 1'b0};
                state_next = S_FLUSH;
            end

            S_FLUSH:
            begin
                emit.flush = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            hv_reg     <= 1'b0;
            hgroup_reg <= '0;
            hrank_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            hv_reg     <= hv_next;
            hgroup_reg <= hgroup_next;
            hrank_reg  <= hrank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        req_reg    <= req_next;
        high_reg   <= high_next;
        notify_reg <= notify_next;
        found_reg  <= found_next;
        demote_reg <= demote_next;
    end

    assign busy = (state_reg != S_IDLE);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write to the same entry in one cycle");

    a_queue_has_holder: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && (count_reg != '0)) |-> hv_reg)
        else $error("waiters queued while the lock is free");

endmodule

// ===== src/group_priority_lock_arbiter.sv =====
// Timing: an item that finishes at once (grant of a free lock, error, queue
//   insert into an empty queue) passes its single result through the output
//   stage's pending and result registers. Busy stays high until the item is
//   closed; start is taken only while busy is low, one item at a time.
// Reset: lock free and queue empty at once; no clearing pass. Results leave on
//   strobe for one cycle each; the receiver cannot stall them.
module group_priority_lock_arbiter
    import gpla_pkg::*;
    #(
        parameter int QUEUE_DEPTH = 16
    )
    (
        input  logic    clk,
        input  logic    rst_n,
        input  logic    start,
        input  cmd_t    cmd,
        output logic    busy,
        output logic    strobe,
        output result_t result
    );

    localparam int AW = $clog2(QUEUE_DEPTH);

    // The waiting queue lives in one memory, kept sorted by ascending group
    // with equal groups in arrival order. Every operation on it is a walk:
    //   acquire   - walk down from the tail, move larger groups up one slot,
    //               drop the new item into the gap;
    //   discard   - walk up from the head, find the first match on group and
    //               requester, move the rest down one slot;
    //   release   - read the head into the holder registers, move the rest
    //               down one slot while demoting the leading high entries.
    // The walk issues one read per cycle; the write of the previous entry
    // always goes to a different address than the read in flight, so no
    // forwarding is needed.

    emit_req_t emit;
    logic      ram_we;
    logic      ram_re;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    entry_t    ram_wdata;
    entry_t    ram_rdata;

    // Sequencer: holder registers, queue count and the memory walk
    gpla_seq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .emit      (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Queue storage, registered read
    gpla_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output stage: hold one result back so the final one of an item is
    // marked last, then drive it out registered
    gpla_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (emit),
        .strobe (strobe),
        .result (result)
    );

endmodule
